// ===== hdl/lz3_pkg.sv =====
// Shared types, constants and helpers for the three-stream LZSS decompressor.
// No dependencies; the command FIFO, front, back and top use it through scoped names.
package lz3_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int BPR        = 8;
  localparam int LANE_W     = $clog2(BPR);
  localparam int DIST_W     = HIST_AW + 1;
  localparam int CNT_W      = 9;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CNT_W-1:0] SHORT_BIAS = 9'd2;
  localparam logic [CNT_W-1:0] LONG_BIAS  = 9'd18;

  typedef enum logic [1:0] {
    NEED_FLAG  = 2'd0,
    NEED_LINK  = 2'd1,
    NEED_CHUNK = 2'd2,
    NEED_DONE  = 2'd3
  } need_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WRONG = 2'd1,
    ST_DIST  = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_EMPTY = 2'd0,
    CMD_LIT   = 2'd1,
    CMD_COPY  = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_COPY = 1'b1
  } back_state_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         lit;
    logic [DIST_W-1:0]  link_dist;
    logic [CNT_W-1:0]   len;
    status_t            status;
    need_t              need;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // stream wanted next, from the decode state
  function automatic need_t need_of(input logic done, input logic link_wait,
                                    input logic bits_zero, input logic top_bit);
    need_t n;
    if (done)           n = NEED_DONE;
    else if (link_wait) n = NEED_CHUNK;
    else if (bits_zero) n = NEED_FLAG;
    else if (top_bit)   n = NEED_CHUNK;
    else                n = NEED_LINK;
    return n;
  endfunction

endpackage

// ===== hdl/lz3_if.sv =====
// Request and result channel interfaces (valid/ready with payload).
// Depends on nothing.
interface lz3_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] in_word;
  modport source(output valid, req_type, in_word, input ready);
  modport sink(input valid, req_type, in_word, output ready);
endinterface

interface lz3_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic [1:0]  next_need;
  logic [1:0]  status;
  logic        last;
  modport source(output valid, out_bytes, byte_count, next_need, status, last, input ready);
  modport sink(input valid, out_bytes, byte_count, next_need, status, last, output ready);
endinterface

// ===== hdl/lz3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lz3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lz3_cmd_fifo.sv =====
// Short command queue between the decode front and the copy back.
// Depends on lz3_pkg.
module lz3_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lz3_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output lz3_pkg::cmd_t       head,
  output lz3_pkg::fifo_stat_t stat
);

  lz3_pkg::cmd_t                 mem [lz3_pkg::FIFO_DEPTH];
  logic [lz3_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [lz3_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [lz3_pkg::FIFO_AW:0]     count;

  assign stat.full  = (count == (lz3_pkg::FIFO_AW+1)'(lz3_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== hdl/lz3_front.sv =====
// Decode front: takes requests, tracks flag/link state and output size,
// and turns each request into one command. Depends on lz3_pkg, lz3_if.
module lz3_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  lz3_req_if.sink             req,
  input  lz3_pkg::fifo_stat_t fstat,
  output logic                push,
  output lz3_pkg::cmd_t       push_cmd
);

  logic [31:0] decoded_size;
  logic [31:0] flag_word, flag_word_next;
  logic [5:0]  bits_left, bits_left_next;
  logic [15:0] held_link, held_link_next;
  logic        link_waiting, link_waiting_next;
  logic [31:0] bytes_produced, bytes_produced_next;

  logic [31:0]                 remain;
  logic                        done;
  lz3_pkg::need_t              need;
  logic                        accept;
  logic                        is_copy;
  logic [lz3_pkg::CNT_W-1:0]   count;
  logic [15:0]                 link_src;
  logic [lz3_pkg::DIST_W-1:0]  link_dist;
  logic                        trunc;
  logic [lz3_pkg::CNT_W-1:0]   len;

  assign remain    = decoded_size - bytes_produced;
  assign done      = (bytes_produced >= decoded_size);
  assign need      = lz3_pkg::need_of(done, link_waiting, bits_left == 6'd0, flag_word[31]);
  assign req.ready = !fstat.full;
  assign accept    = req.valid && req.ready;
  assign push      = accept;

  // classify the request and work out the state after it
  always_comb begin
    flag_word_next      = flag_word;
    bits_left_next      = bits_left;
    held_link_next      = held_link;
    link_waiting_next   = link_waiting;
    bytes_produced_next = bytes_produced;
    is_copy             = 1'b0;
    count               = '0;
    link_src            = held_link;
    link_dist           = '0;
    trunc               = 1'b0;
    len                 = '0;
    push_cmd.kind       = lz3_pkg::CMD_EMPTY;
    push_cmd.lit        = '0;
    push_cmd.link_dist  = '0;
    push_cmd.len        = '0;
    push_cmd.status     = lz3_pkg::ST_OK;
    push_cmd.need       = need;

    if (done || (req.req_type != need)) begin
      push_cmd.status = lz3_pkg::ST_WRONG;
    end else begin
      case (need)
        lz3_pkg::NEED_FLAG: begin
          flag_word_next = req.in_word;
          bits_left_next = 6'd32;
          push_cmd.need  = lz3_pkg::need_of(1'b0, 1'b0, 1'b0, req.in_word[31]);
        end
        lz3_pkg::NEED_LINK: begin
          held_link_next = req.in_word[15:0];
          link_src       = req.in_word[15:0];
          if (req.in_word[15:12] == 4'd0) begin
            link_waiting_next = 1'b1;
            push_cmd.need     = lz3_pkg::NEED_CHUNK;
          end else begin
            is_copy = 1'b1;
            count   = {5'd0, req.in_word[15:12]} + lz3_pkg::SHORT_BIAS;
          end
        end
        lz3_pkg::NEED_CHUNK: begin
          if (link_waiting) begin
            link_waiting_next = 1'b0;
            is_copy           = 1'b1;
            count             = {1'b0, req.in_word[7:0]} + lz3_pkg::LONG_BIAS;
          end else begin
            push_cmd.kind       = lz3_pkg::CMD_LIT;
            push_cmd.lit        = req.in_word[7:0];
            bytes_produced_next = bytes_produced + 32'd1;
            flag_word_next      = {flag_word[30:0], 1'b0};
            bits_left_next      = bits_left - 6'd1;
            push_cmd.need       = lz3_pkg::need_of(remain == 32'd1, 1'b0,
                                                   bits_left == 6'd1, flag_word[30]);
          end
        end
        default: begin
          push_cmd.status = lz3_pkg::ST_WRONG;
        end
      endcase

      // back-reference: clip to the bytes left, check the distance
      if (is_copy) begin
        link_dist = {1'b0, link_src[11:0]} + lz3_pkg::DIST_W'(1);
        trunc     = ({23'd0, count} > remain);
        len       = trunc ? remain[lz3_pkg::CNT_W-1:0] : count;
        push_cmd.kind      = lz3_pkg::CMD_COPY;
        push_cmd.link_dist = link_dist;
        push_cmd.len       = len;
        if ({19'd0, link_dist} > bytes_produced) push_cmd.status = lz3_pkg::ST_DIST;
        else if (trunc)                          push_cmd.status = lz3_pkg::ST_TRUNC;
        bytes_produced_next = bytes_produced + {23'd0, len};
        flag_word_next      = {flag_word[30:0], 1'b0};
        bits_left_next      = bits_left - 6'd1;
        push_cmd.need       = lz3_pkg::need_of({23'd0, count} >= remain, 1'b0,
                                               bits_left == 6'd1, flag_word[30]);
      end
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      decoded_size   <= '0;
      flag_word      <= '0;
      bits_left      <= '0;
      held_link      <= '0;
      link_waiting   <= 1'b0;
      bytes_produced <= '0;
    end else begin
      if (cfg_we) decoded_size <= cfg_wdata;
      if (accept) begin
        flag_word      <= flag_word_next;
        bits_left      <= bits_left_next;
        held_link      <= held_link_next;
        link_waiting   <= link_waiting_next;
        bytes_produced <= bytes_produced_next;
      end
    end
  end

endmodule

// ===== hdl/lz3_back.sv =====
// Copy back: runs commands against the history RAM and packs output bytes
// into results. Depends on lz3_pkg, lz3_if, lz3_ram.
module lz3_back (
  input  logic                clk,
  input  logic                rst,
  input  lz3_pkg::fifo_stat_t fstat,
  input  lz3_pkg::cmd_t       head,
  output logic                pop,
  lz3_res_if.source           res
);

  lz3_pkg::back_state_t        state, state_next;
  logic [31:0]                 wp;
  logic [7:0]                  prev;
  logic [lz3_pkg::DIST_W-1:0]  link_dist;
  logic [lz3_pkg::CNT_W-1:0]   left;
  lz3_pkg::status_t            cstatus;
  lz3_pkg::need_t              cneed;
  logic [lz3_pkg::LANE_W-1:0]  lane;
  logic [63:0]                 acc;

  logic                        ovalid;
  logic [63:0]                 o_bytes;
  logic [3:0]                  o_count;
  lz3_pkg::need_t              o_need;
  lz3_pkg::status_t            o_status;
  logic                        o_last;

  logic                        we, re;
  logic [lz3_pkg::HIST_AW-1:0] waddr, raddr;
  logic [7:0]                  wdata, rdata;

  logic                        emit_ok, step, copy_emit, emit, start_copy;
  logic [7:0]                  byte_c;
  logic [63:0]                 lane_acc;
  logic [63:0]                 e_bytes;
  logic [3:0]                  e_count;
  lz3_pkg::need_t              e_need;
  lz3_pkg::status_t            e_status;
  logic                        e_last;

  lz3_ram #(.WIDTH(8), .DEPTH(lz3_pkg::HIST_DEPTH)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  // source byte: zero before start, last byte for distance one, else RAM
  assign emit_ok   = !ovalid || res.ready;
  assign byte_c    = (wp < {19'd0, link_dist}) ? 8'd0 :
                     (link_dist == lz3_pkg::DIST_W'(1)) ? prev : rdata;
  assign lane_acc  = acc | ({56'd0, byte_c} << {lane, 3'b000});
  assign copy_emit = (lane == lz3_pkg::LANE_W'(lz3_pkg::BPR - 1)) ||
                     (left == lz3_pkg::CNT_W'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lz3_pkg::BK_IDLE: begin
        if (!fstat.empty && head.kind == lz3_pkg::CMD_COPY) state_next = lz3_pkg::BK_COPY;
      end
      lz3_pkg::BK_COPY: begin
        if (step && left == lz3_pkg::CNT_W'(1)) state_next = lz3_pkg::BK_IDLE;
      end
      default: state_next = lz3_pkg::BK_IDLE;
    endcase
  end

  // outputs: queue pop, RAM ports, result load
  always_comb begin
    pop        = 1'b0;
    start_copy = 1'b0;
    step       = 1'b0;
    we         = 1'b0;
    waddr      = wp[lz3_pkg::HIST_AW-1:0];
    wdata      = byte_c;
    re         = 1'b0;
    raddr      = wp[lz3_pkg::HIST_AW-1:0] + 1'b1 - link_dist[lz3_pkg::HIST_AW-1:0];
    emit       = 1'b0;
    e_bytes    = lane_acc;
    e_count    = 4'({1'b0, lane}) + 4'd1;
    e_need     = cneed;
    e_status   = cstatus;
    e_last     = (left == lz3_pkg::CNT_W'(1));
    case (state)
      lz3_pkg::BK_IDLE: begin
        e_need   = head.need;
        e_status = head.status;
        e_last   = 1'b1;
        if (!fstat.empty) begin
          case (head.kind)
            lz3_pkg::CMD_EMPTY: begin
              if (emit_ok) begin
                pop     = 1'b1;
                emit    = 1'b1;
                e_bytes = '0;
                e_count = 4'd0;
              end
            end
            lz3_pkg::CMD_LIT: begin
              if (emit_ok) begin
                pop     = 1'b1;
                emit    = 1'b1;
                we      = 1'b1;
                wdata   = head.lit;
                e_bytes = {56'd0, head.lit};
                e_count = 4'd1;
              end
            end
            lz3_pkg::CMD_COPY: begin
              pop        = 1'b1;
              start_copy = 1'b1;
              re         = 1'b1;
              raddr      = wp[lz3_pkg::HIST_AW-1:0] -
                           head.link_dist[lz3_pkg::HIST_AW-1:0];
            end
            default: pop = 1'b1;
          endcase
        end
      end
      lz3_pkg::BK_COPY: begin
        step = !copy_emit || emit_ok;
        if (step) begin
          we   = 1'b1;
          re   = 1'b1;
          emit = copy_emit;
        end
      end
      default: ;
    endcase
  end

  // control and copy registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lz3_pkg::BK_IDLE;
      ovalid <= 1'b0;
      wp     <= '0;
      lane   <= '0;
    end else begin
      state <= state_next;
      if (emit)           ovalid <= 1'b1;
      else if (res.ready) ovalid <= 1'b0;
      if (step || (pop && head.kind == lz3_pkg::CMD_LIT)) wp <= wp + 32'd1;
      if (start_copy || (step && copy_emit)) lane <= '0;
      else if (step)                         lane <= lane + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_copy) begin
      link_dist <= head.link_dist;
      left      <= head.len;
      cstatus   <= head.status;
      cneed     <= head.need;
      acc       <= '0;
    end
    if (pop && head.kind == lz3_pkg::CMD_LIT) prev <= head.lit;
    if (step) begin
      prev <= byte_c;
      left <= left - 1'b1;
      acc  <= copy_emit ? 64'd0 : lane_acc;
    end
    if (emit) begin
      o_bytes  <= e_bytes;
      o_count  <= e_count;
      o_need   <= e_need;
      o_status <= e_status;
      o_last   <= e_last;
    end
  end

  assign res.valid      = ovalid;
  assign res.out_bytes  = o_bytes;
  assign res.byte_count = o_count;
  assign res.next_need  = o_need;
  assign res.status     = o_status;
  assign res.last       = o_last;

  // checks
  a_copy_left: assert property (@(posedge clk) disable iff (rst)
    state == lz3_pkg::BK_COPY |-> left != '0) else $error("copy with no bytes left");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> emit_ok) else $error("pending result overwritten");
  a_full_results: assert property (@(posedge clk) disable iff (rst)
    ovalid && !o_last |-> o_count == 4'(lz3_pkg::BPR)) else $error("short non-final result");
  a_copy_start: assert property (@(posedge clk) disable iff (rst)
    start_copy |=> state == lz3_pkg::BK_COPY) else $error("copy did not start");

endmodule

// ===== hdl/lzss_three_stream_decompressor_top.sv =====
// Flow: a flag, link-with-extension, wrong-stream or literal request is queued when accepted
//   and the back registers its result; a copy is read back from the history RAM (one history
//   RAM read per byte) and packed into results. Requests enter one per cycle while the
//   4-entry queue has room; the back takes one queued command at a time, finishing each
//   copy first, and holds while a result is not taken. Reset (rst, synchronous) clears
//   decode state, size, queue and output; history RAM contents are not cleared.
module lzss_three_stream_decompressor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  lz3_req_if.sink     req,
  lz3_res_if.source   res
);

  lz3_pkg::fifo_stat_t fstat;
  lz3_pkg::cmd_t       push_cmd, head;
  logic                push, pop;

  lz3_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req), .fstat(fstat), .push(push), .push_cmd(push_cmd)
  );

  lz3_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd),
    .pop(pop), .head(head), .stat(fstat)
  );

  lz3_back u_back (
    .clk(clk), .rst(rst), .fstat(fstat), .head(head), .pop(pop), .res(res)
  );

endmodule
